/* rtl/core/tpq_pkg.sv */
`timescale 1ns / 1ps

package tpq_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int CFG_W      = 11;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 49;
  localparam int N_MIX      = 7;
  localparam int MIX_W      = $clog2(N_MIX);

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_NEAR = 2'd1;
  localparam logic [1:0] REQ_STAT = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_NEAR = 2'd1;
  localparam logic [1:0] ST_STAT = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [IDX_W-1:0]   point_index;
    logic signed [31:0] station;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic signed [31:0] curvature;
    logic signed [31:0] speed;
    logic signed [31:0] left_edge;
    logic signed [31:0] right_edge;
  } tpq_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [IDX_W-1:0]   found_index;
    logic [31:0]        distance;
    logic signed [31:0] out_station;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [15:0]        out_heading;
    logic signed [31:0] out_curvature;
    logic signed [31:0] out_speed;
    logic signed [31:0] out_left_edge;
    logic signed [31:0] out_right_edge;
  } tpq_rsp_t;

  typedef struct packed {
    logic signed [31:0] station;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        heading;
    logic signed [31:0] curvature;
    logic signed [31:0] speed;
    logic signed [31:0] left_edge;
    logic signed [31:0] right_edge;
  } tpq_row_t;

  typedef enum logic [2:0] {
    RD_CNT, RD_LAST, RD_ZERO, RD_MID, RD_HI, RD_LO, RD_BEST
  } rd_sel_t;

  typedef enum logic [2:0] {
    SR_NONE, SR_LAST, SR_ZERO, SR_INIT, SR_STEP, SR_FIN
  } srch_op_t;

  typedef enum logic [1:0] {
    RES_LOAD, RES_NEAR, RES_STEQ, RES_STMIX
  } res_kind_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_SCAN, S_DRAIN, S_SQRT, S_NRD, S_RDLAST, S_CHKLAST,
    S_CHKFIRST, S_MIDRD, S_MIDCHK, S_RDHI, S_RDLO, S_GRABLO, S_EQCHK,
    S_DIV, S_WSAT, S_MUL, S_ACC, S_FIN
  } state_t;

  typedef struct packed {
    logic             capture;
    logic             mem_we;
    logic             rd_en;
    rd_sel_t          rd_sel;
    logic             scan;
    srch_op_t         srch_op;
    logic             grab_hi;
    logic             grab_lo;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             div_init;
    logic             div_step;
    logic             w_load;
    logic             mix_mul;
    logic             mix_acc;
    logic             res_load;
    res_kind_t        res_kind;
    logic [CNT_W-1:0] cnt;
  } tpq_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic pipe_busy;
    logic q_ge_rd;
    logic q_lt_rd;
    logic srch_empty;
    logic st_equal;
    logic out_free;
  } tpq_sts_t;

endpackage

/* rtl/core/tpq_req_if.sv */
`timescale 1ns / 1ps

interface tpq_req_if import tpq_pkg::*; ();
  logic     valid;
  logic     ready;
  tpq_req_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* rtl/core/tpq_rsp_if.sv */
`timescale 1ns / 1ps

interface tpq_rsp_if import tpq_pkg::*; ();
  logic     valid;
  logic     ready;
  tpq_rsp_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* rtl/core/tpq_ctrl.sv */
`timescale 1ns / 1ps

module tpq_ctrl import tpq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_type,
  input  tpq_sts_t   sts,
  output logic       in_ready,
  output tpq_cmd_t   cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  res_kind_t        kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      kind_r  <= RES_LOAD;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    kind_nxt  = kind_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.rd_sel   = RD_CNT;
    cmd.srch_op  = SR_NONE;
    cmd.res_kind = kind_r;
    cmd.cnt      = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (in_type)
            REQ_LOAD: state_nxt = S_LOAD;
            REQ_NEAR: state_nxt = S_SCAN;
            REQ_STAT: state_nxt = S_RDLAST;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd.mem_we = 1'b1;
        kind_nxt   = RES_LOAD;
        state_nxt  = S_FIN;
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        cmd.scan  = 1'b1;
        if (sts.cnt_last) begin
          cnt_nxt   = '0;
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          cmd.sqrt_init = 1'b1;
          state_nxt     = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          state_nxt = S_NRD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_NRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_BEST;
        kind_nxt   = RES_NEAR;
        state_nxt  = S_FIN;
      end
      S_RDLAST: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_LAST;
        state_nxt  = S_CHKLAST;
      end
      S_CHKLAST: begin
        if (sts.q_ge_rd) begin
          cmd.srch_op = SR_LAST;
          state_nxt   = S_RDHI;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_ZERO;
          state_nxt  = S_CHKFIRST;
        end
      end
      S_CHKFIRST: begin
        if (sts.q_lt_rd) begin
          cmd.srch_op = SR_ZERO;
          state_nxt   = S_RDHI;
        end else begin
          cmd.srch_op = SR_INIT;
          state_nxt   = S_MIDRD;
        end
      end
      S_MIDRD: begin
        if (sts.srch_empty) begin
          cmd.srch_op = SR_FIN;
          state_nxt   = S_RDHI;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_MID;
          state_nxt  = S_MIDCHK;
        end
      end
      S_MIDCHK: begin
        cmd.srch_op = SR_STEP;
        state_nxt   = S_MIDRD;
      end
      S_RDHI: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_HI;
        state_nxt  = S_RDLO;
      end
      S_RDLO: begin
        cmd.grab_hi = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RD_LO;
        state_nxt   = S_GRABLO;
      end
      S_GRABLO: begin
        cmd.grab_lo = 1'b1;
        state_nxt   = S_EQCHK;
      end
      S_EQCHK: begin
        if (sts.st_equal) begin
          kind_nxt  = RES_STEQ;
          state_nxt = S_FIN;
        end else begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_WSAT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_WSAT: begin
        cmd.w_load = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mix_mul = 1'b1;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        cmd.mix_acc = 1'b1;
        if (cnt_r == CNT_W'(N_MIX - 1)) begin
          kind_nxt  = RES_STMIX;
          state_nxt = S_FIN;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* rtl/core/tpq_dp.sv */
`timescale 1ns / 1ps

module tpq_dp import tpq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  tpq_req_t         in_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  tpq_cmd_t         cmd,
  output tpq_sts_t         sts,
  output logic             out_valid,
  input  logic             out_ready,
  output tpq_rsp_t         out_data
);

  localparam logic [MIX_W-1:0] MIX_X     = MIX_W'(0);
  localparam logic [MIX_W-1:0] MIX_Y     = MIX_W'(1);
  localparam logic [MIX_W-1:0] MIX_HEAD  = MIX_W'(2);
  localparam logic [MIX_W-1:0] MIX_CURV  = MIX_W'(3);
  localparam logic [MIX_W-1:0] MIX_SPEED = MIX_W'(4);
  localparam logic [MIX_W-1:0] MIX_LEFT  = MIX_W'(5);
  localparam logic [MIX_W-1:0] MIX_RIGHT = MIX_W'(6);

  // config and request
  logic [CFG_W-1:0] cfg_r;
  tpq_req_t         req_r;
  logic [CNT_W-1:0] n_w;
  logic [IDX_W-1:0] last_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_W'(2);
    end else if (cfg_we) begin
      cfg_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
  end

  always_comb begin
    if (cfg_r < CFG_W'(2)) begin
      n_w = CNT_W'(2);
    end else if (CNT_W'(cfg_r) > CNT_W'(MAX_POINTS) || cfg_r > CFG_W'(MAX_POINTS)) begin
      n_w = CNT_W'(MAX_POINTS);
    end else begin
      n_w = CNT_W'(cfg_r);
    end
    last_idx = IDX_W'(n_w - 1'b1);
  end

  // point memory
  tpq_row_t         mem [MAX_POINTS];
  tpq_row_t         rd_data_r;
  tpq_row_t         wr_row;
  logic [IDX_W-1:0] rd_addr;
  logic [CNT_W-1:0] srch_lo_r, srch_cnt_r;
  logic [IDX_W-1:0] hi_r, best_idx_r, mid_w;

  assign wr_row = '{station: req_r.station, x: req_r.pos_x, y: req_r.pos_y,
                    heading: req_r.heading, curvature: req_r.curvature,
                    speed: req_r.speed, left_edge: req_r.left_edge,
                    right_edge: req_r.right_edge};

  assign mid_w = IDX_W'(srch_lo_r + (srch_cnt_r >> 1));

  always_comb begin
    case (cmd.rd_sel)
      RD_CNT:  rd_addr = cmd.cnt[IDX_W-1:0];
      RD_LAST: rd_addr = last_idx;
      RD_ZERO: rd_addr = '0;
      RD_MID:  rd_addr = mid_w;
      RD_HI:   rd_addr = hi_r;
      RD_LO:   rd_addr = hi_r - 1'b1;
      RD_BEST: rd_addr = best_idx_r;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[req_r.point_index] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // nearest scan pipeline: read -> abs diff -> square -> compare
  logic              rdv_r, s1v_r, s2v_r;
  logic [IDX_W-1:0]  rtag_r, s1tag_r, s2tag_r;
  logic [31:0]       ax_r, ay_r;
  logic [63:0]       sqx_r, sqy_r;
  logic [64:0]       best_r, sum_w;
  logic signed [32:0] dx_s, dy_s;

  always_comb begin
    dx_s  = {rd_data_r.x[31], rd_data_r.x} - {req_r.pos_x[31], req_r.pos_x};
    dy_s  = {rd_data_r.y[31], rd_data_r.y} - {req_r.pos_y[31], req_r.pos_y};
    sum_w = {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r <= 1'b0;
      s1v_r <= 1'b0;
      s2v_r <= 1'b0;
    end else begin
      rdv_r <= cmd.rd_en && cmd.scan;
      s1v_r <= rdv_r;
      s2v_r <= s1v_r;
    end
  end

  always_ff @(posedge clk) begin
    rtag_r  <= cmd.cnt[IDX_W-1:0];
    s1tag_r <= rtag_r;
    s2tag_r <= s1tag_r;
    ax_r    <= dx_s[32] ? 32'(-dx_s) : dx_s[31:0];
    ay_r    <= dy_s[32] ? 32'(-dy_s) : dy_s[31:0];
    sqx_r   <= ax_r * ax_r;
    sqy_r   <= ay_r * ay_r;
    if (s2v_r && (s2tag_r == '0 || sum_w < best_r)) begin
      best_r     <= sum_w;
      best_idx_r <= s2tag_r;
    end
  end

  // digit-by-digit square root, one result bit per cycle
  logic [63:0] sq_v_r;
  logic [33:0] sq_rem_r;
  logic [31:0] sq_root_r;
  logic [34:0] sq_t, sq_trial;

  always_comb begin
    sq_t     = {sq_rem_r[32:0], sq_v_r[63:62]};
    sq_trial = {1'b0, sq_root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sq_v_r    <= best_r[63:0];
      sq_rem_r  <= '0;
      sq_root_r <= '0;
    end else if (cmd.sqrt_step) begin
      sq_v_r <= {sq_v_r[61:0], 2'b00};
      if (sq_t >= sq_trial) begin
        sq_rem_r  <= 34'(sq_t - sq_trial);
        sq_root_r <= {sq_root_r[30:0], 1'b1};
      end else begin
        sq_rem_r  <= sq_t[33:0];
        sq_root_r <= {sq_root_r[30:0], 1'b0};
      end
    end
  end

  // lower-bound search bracket
  logic             q_lt_mid;
  logic [CNT_W-1:0] fin_w;

  assign q_lt_mid = $signed(rd_data_r.station) < $signed(req_r.station);
  assign fin_w    = (srch_lo_r < n_w) ? srch_lo_r : n_w - 1'b1;

  always_ff @(posedge clk) begin
    case (cmd.srch_op)
      SR_LAST: hi_r <= last_idx;
      SR_ZERO: hi_r <= IDX_W'(1);
      SR_INIT: begin
        srch_lo_r  <= '0;
        srch_cnt_r <= n_w;
      end
      SR_STEP: begin
        if (q_lt_mid) begin
          srch_lo_r  <= CNT_W'(mid_w) + 1'b1;
          srch_cnt_r <= srch_cnt_r - (srch_cnt_r >> 1) - 1'b1;
        end else begin
          srch_cnt_r <= srch_cnt_r >> 1;
        end
      end
      SR_FIN:  hi_r <= (fin_w == '0) ? IDX_W'(1) : IDX_W'(fin_w);
      default: ;
    endcase
  end

  // bracket rows
  tpq_row_t lo_row_r, hi_row_r;

  always_ff @(posedge clk) begin
    if (cmd.grab_hi) begin
      hi_row_r <= rd_data_r;
    end
    if (cmd.grab_lo) begin
      lo_row_r <= rd_data_r;
    end
  end

  // weight divider, restoring, one quotient bit per cycle
  logic [48:0]        dvd_r;
  logic [32:0]        dvs_r, drem_r;
  logic               neg_r;
  logic signed [32:0] num_w, den_w;
  logic [33:0]        dr_w;
  logic signed [31:0] w_r;

  always_comb begin
    num_w = {req_r.station[31], req_r.station} - {lo_row_r.station[31], lo_row_r.station};
    den_w = {hi_row_r.station[31], hi_row_r.station} -
            {lo_row_r.station[31], lo_row_r.station};
    dr_w  = {drem_r, dvd_r[48]};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dvd_r  <= {(num_w[32] ? 33'(-num_w) : 33'(num_w)), 16'b0};
      dvs_r  <= den_w[32] ? 33'(-den_w) : 33'(den_w);
      neg_r  <= num_w[32] ^ den_w[32];
      drem_r <= '0;
    end else if (cmd.div_step) begin
      if (dr_w >= {1'b0, dvs_r}) begin
        drem_r <= 33'(dr_w - {1'b0, dvs_r});
        dvd_r  <= {dvd_r[47:0], 1'b1};
      end else begin
        drem_r <= dr_w[32:0];
        dvd_r  <= {dvd_r[47:0], 1'b0};
      end
    end
    if (cmd.w_load) begin
      if (neg_r) begin
        w_r <= (dvd_r > 49'h0_8000_0000) ? 32'sh8000_0000 : 32'(-dvd_r);
      end else begin
        w_r <= (dvd_r > 49'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : dvd_r[31:0];
      end
    end
  end

  // interpolation, one field at a time on a shared multiplier: multiply, then accumulate
  logic [MIX_W-1:0]   fsel;
  logic [31:0]        a0_w, a1_w;
  logic [15:0]        dh_w;
  logic signed [32:0] a_w, d_w, a_r;
  logic signed [64:0] prod_r, acc_w;
  logic [31:0]        mix_r [N_MIX];
  logic [31:0]        acc_sat;

  assign fsel = cmd.cnt[MIX_W-1:0];

  always_comb begin
    case (fsel)
      MIX_X:     begin a0_w = lo_row_r.x;          a1_w = hi_row_r.x;          end
      MIX_Y:     begin a0_w = lo_row_r.y;          a1_w = hi_row_r.y;          end
      MIX_CURV:  begin a0_w = lo_row_r.curvature;  a1_w = hi_row_r.curvature;  end
      MIX_SPEED: begin a0_w = lo_row_r.speed;      a1_w = hi_row_r.speed;      end
      MIX_LEFT:  begin a0_w = lo_row_r.left_edge;  a1_w = hi_row_r.left_edge;  end
      MIX_RIGHT: begin a0_w = lo_row_r.right_edge; a1_w = hi_row_r.right_edge; end
      default:   begin a0_w = '0;                  a1_w = '0;                  end
    endcase
    dh_w = hi_row_r.heading - lo_row_r.heading;
    if (fsel == MIX_HEAD) begin
      a_w = {17'b0, lo_row_r.heading};
      d_w = {{17{dh_w[15]}}, dh_w};
    end else begin
      a_w = {a0_w[31], a0_w};
      d_w = {a1_w[31], a1_w} - {a0_w[31], a0_w};
    end
    acc_w = 65'(a_r) + (prod_r >>> 16);
    if (fsel == MIX_HEAD) begin
      acc_sat = {16'b0, acc_w[15:0]};
    end else if (acc_w > 65'sh0_7FFF_FFFF) begin
      acc_sat = 32'h7FFF_FFFF;
    end else if (acc_w < -65'sh0_8000_0000) begin
      acc_sat = 32'h8000_0000;
    end else begin
      acc_sat = acc_w[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mix_mul) begin
      prod_r <= 65'(w_r) * 65'(d_w);
      a_r    <= a_w;
    end
    if (cmd.mix_acc) begin
      mix_r[fsel] <= acc_sat;
    end
  end

  // result register
  tpq_rsp_t res_w;
  tpq_rsp_t out_r;
  logic     out_valid_r;

  always_comb begin
    res_w = '0;
    case (cmd.res_kind)
      RES_LOAD: begin
        res_w.status      = ST_LOAD;
        res_w.found_index = req_r.point_index;
      end
      RES_NEAR: begin
        res_w.status         = ST_NEAR;
        res_w.found_index    = best_idx_r;
        res_w.distance       = best_r[64] ? 32'hFFFF_FFFF : sq_root_r;
        res_w.out_station    = rd_data_r.station;
        res_w.out_x          = rd_data_r.x;
        res_w.out_y          = rd_data_r.y;
        res_w.out_heading    = rd_data_r.heading;
        res_w.out_curvature  = rd_data_r.curvature;
        res_w.out_speed      = rd_data_r.speed;
        res_w.out_left_edge  = rd_data_r.left_edge;
        res_w.out_right_edge = rd_data_r.right_edge;
      end
      RES_STEQ: begin
        res_w.status         = ST_STAT;
        res_w.found_index    = hi_r;
        res_w.out_station    = lo_row_r.station;
        res_w.out_x          = lo_row_r.x;
        res_w.out_y          = lo_row_r.y;
        res_w.out_heading    = lo_row_r.heading;
        res_w.out_curvature  = lo_row_r.curvature;
        res_w.out_speed      = lo_row_r.speed;
        res_w.out_left_edge  = lo_row_r.left_edge;
        res_w.out_right_edge = lo_row_r.right_edge;
      end
      RES_STMIX: begin
        res_w.status         = ST_STAT;
        res_w.found_index    = hi_r;
        res_w.out_station    = req_r.station;
        res_w.out_x          = mix_r[MIX_X];
        res_w.out_y          = mix_r[MIX_Y];
        res_w.out_heading    = mix_r[MIX_HEAD][15:0];
        res_w.out_curvature  = mix_r[MIX_CURV];
        res_w.out_speed      = mix_r[MIX_SPEED];
        res_w.out_left_edge  = mix_r[MIX_LEFT];
        res_w.out_right_edge = mix_r[MIX_RIGHT];
      end
      default: res_w = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_r <= res_w;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // status back to the controller
  always_comb begin
    sts.cnt_last   = (cmd.cnt == n_w - 1'b1);
    sts.pipe_busy  = rdv_r | s1v_r | s2v_r;
    sts.q_ge_rd    = $signed(req_r.station) >= $signed(rd_data_r.station);
    sts.q_lt_rd    = $signed(req_r.station) < $signed(rd_data_r.station);
    sts.srch_empty = (srch_cnt_r == '0);
    sts.st_equal   = (lo_row_r.station == hi_row_r.station);
    sts.out_free   = !out_valid_r || out_ready;
  end

endmodule

/* rtl/core/trajectory_point_table_query.sv */
`timescale 1ns / 1ps

// Trajectory point table with nearest-point and station queries.
// in_if (valid/ready) carries one request: load a point into a slot,
// find the nearest loaded point to (pos_x, pos_y), or evaluate the path
// at a station. out_if (valid/ready) returns one result per request;
// req_type 3 is dropped without a result. cfg_we/cfg_data set the number
// of points in use (clamped to 2..1024); the user must write them only
// while idle, and the block does not enforce this. One request is in
// flight at a time; in_if.ready is high while idle. A nearest query
// scans one point per cycle from the single memory read port, then runs
// a 32-step square root. A station query brackets the station and, unless
// the bracketing rows share a station, runs the 49-step weight divider and
// seven interpolations on one shared multiplier.
// Results sit in an output register; if the receiver stalls, the block
// finishes the next request and holds it until that register frees.
// Reset (rst_n, synchronous) clears control state and sets points in use
// to 2; table contents are undefined until loaded.
module trajectory_point_table_query import tpq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  tpq_req_if.sink          in_if,
  tpq_rsp_if.source        out_if,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  tpq_cmd_t cmd;
  tpq_sts_t sts;
  logic     in_ready;

  assign in_if.ready = in_ready;

  // sequencer: walks scan, search, divide and interpolate steps
  tpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_type  (in_if.data.req_type),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // table memory, arithmetic units and output register
  tpq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_if.data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (out_if.data)
  );

endmodule
